FILE: hw/rtl/lts_pkg.sv
package lts_pkg;

	localparam int IDX_W = 6;

	typedef struct packed {
		logic signed [31:0] column_entry;
		logic signed [31:0] rhs_entry;
		logic               is_last;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] solution_value;
		logic [5:0]         solution_index;
		logic               last_element;
		logic               singular;
	} out_item_t;

	typedef enum logic [2:0] {
		MUL_TB, MUL_EE, MUL_ED, MUL_BD, MUL_FN, MUL_TX, MUL_BZ
	} mul_sel_t;

	typedef enum logic [2:0] {
		ACC_HOLD, ACC_CLR, ACC_SET, ACC_ADD, ACC_LDX
	} acc_op_t;

	typedef enum logic [2:0] {
		LAT_NONE, LAT_E, LAT_DEN, LAT_D, LAT_NED, LAT_Z
	} lat_op_t;

	typedef struct packed {
		logic             load_wr;
		logic [IDX_W-1:0] load_addr;
		logic             rd_en;
		logic [IDX_W-1:0] coef_addr;
		logic [IDX_W-1:0] rhs_addr;
		logic [IDX_W-1:0] x_addr;
		logic [IDX_W:0]   b0_addr;
		logic [IDX_W:0]   b1_addr;
		mul_sel_t         mul_sel;
		logic             mul_en;
		acc_op_t          acc_op;
		lat_op_t          lat_op;
		logic             b_wr;
		logic [IDX_W:0]   b_wr_addr;
		logic             x_wr;
		logic [IDX_W-1:0] x_wr_addr;
		logic             wr_from_div;
		logic             div_start;
		logic             div_num_rhs;
		logic             div_den_coef;
		logic             sing_clr;
		logic             out_valid;
		logic             out_last;
		logic [5:0]       out_index;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_done;
	} dp_status_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

endpackage

FILE: hw/rtl/lts_div.sv
module lts_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] num,
	input  logic signed [31:0] den,
	output logic               done,
	output logic               zero,
	output logic signed [31:0] quo
);

	logic [63:0] work_q;
	logic [33:0] rem_q;
	logic [33:0] dvs_q;
	logic [5:0]  step_q;
	logic        run_q;
	logic        neg_q;
	logic        zero_q;
	logic        done_q;

	logic [63:0] un;
	logic [32:0] ud;
	logic [34:0] trial;
	logic        fits;

	assign un    = num[63] ? (64'd0 - num) : num;
	assign ud    = den[31] ? (33'd0 - {den[31], den}) : {den[31], den};
	assign trial = {rem_q, work_q[63]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				work_q <= {un[62:0], 1'b0} + {31'd0, ud};
				dvs_q  <= {ud, 1'b0};
				rem_q  <= '0;
				neg_q  <= num[63] ^ den[31];
				zero_q <= (den == 32'sd0);
				step_q <= '0;
				run_q  <= 1'b1;
			end else if (run_q) begin
				// one quotient bit per cycle, restoring
				rem_q  <= fits ? 34'(trial - {1'b0, dvs_q}) : trial[33:0];
				work_q <= {work_q[62:0], fits};
				step_q <= step_q + 6'd1;
				if (step_q == 6'd63) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		if (zero_q)
			quo = '0;
		else if (neg_q)
			quo = (work_q > 64'h80000000) ? 32'sh80000000 : 32'(64'd0 - work_q);
		else
			quo = (work_q > 64'h7fffffff) ? 32'sh7fffffff : work_q[31:0];
	end

	assign done = done_q;
	assign zero = zero_q;

endmodule

FILE: hw/rtl/lts_dpath.sv
module lts_dpath #(
	parameter int MAX_ORDER = 32,
	parameter int FRAC_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lts_pkg::in_item_t   item,
	input  lts_pkg::ctrl_cmd_t  cmd,
	output lts_pkg::dp_status_t status,
	output logic signed [31:0]  x_value,
	output logic                singular
);

	localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam logic signed [63:0] ONE    = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] HALF   = 64'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [63:0] ONE_SQ = 64'sd1 <<< (2 * FRAC_BITS);

	logic signed [31:0] coef_mem [MAX_ORDER];
	logic signed [31:0] rhs_mem  [MAX_ORDER];
	logic signed [31:0] x_mem    [MAX_ORDER];
	logic signed [31:0] b_mem    [2**(AW+1)];

	logic signed [31:0] coef_rd_q, rhs_rd_q, x_rd_q, b0_rd_q, b1_rd_q;
	logic signed [31:0] e_q, den_q, d_q, ned_q, z_q;
	logic signed [63:0] p_s1;
	logic signed [63:0] acc_q;
	logic               sing_q;

	logic signed [31:0] op_a, op_b;
	logic signed [63:0] prod;
	logic signed [63:0] rnd;
	logic signed [31:0] sat_acc;
	logic signed [31:0] wr_data;
	logic signed [63:0] div_num;
	logic signed [31:0] div_den;
	logic               div_done, div_zero;
	logic signed [31:0] div_quo;
	logic [AW:0]        b0_a, b1_a, bw_a;

	lts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.zero   (div_zero),
		.quo    (div_quo)
	);

	assign div_num = cmd.div_num_rhs ? (64'(rhs_rd_q) <<< FRAC_BITS) : ONE_SQ;
	assign div_den = cmd.div_den_coef ? coef_rd_q : den_q;

	// bank bit on top, element index below
	assign b0_a = {cmd.b0_addr[lts_pkg::IDX_W], cmd.b0_addr[AW-1:0]};
	assign b1_a = {cmd.b1_addr[lts_pkg::IDX_W], cmd.b1_addr[AW-1:0]};
	assign bw_a = {cmd.b_wr_addr[lts_pkg::IDX_W], cmd.b_wr_addr[AW-1:0]};

	always_comb begin
		case (cmd.mul_sel)
			lts_pkg::MUL_TB: begin op_a = coef_rd_q; op_b = b0_rd_q; end
			lts_pkg::MUL_EE: begin op_a = e_q;       op_b = e_q;     end
			lts_pkg::MUL_ED: begin op_a = e_q;       op_b = d_q;     end
			lts_pkg::MUL_BD: begin op_a = b0_rd_q;   op_b = d_q;     end
			lts_pkg::MUL_FN: begin op_a = b1_rd_q;   op_b = ned_q;   end
			lts_pkg::MUL_TX: begin op_a = coef_rd_q; op_b = x_rd_q;  end
			lts_pkg::MUL_BZ: begin op_a = b0_rd_q;   op_b = z_q;     end
			default:         begin op_a = '0;        op_b = '0;      end
		endcase
	end

	// full 64-bit signed product of the two 32-bit operands
	assign prod = op_a * op_b;

	// round half up, floor shift
	assign rnd     = (p_s1 + HALF) >>> FRAC_BITS;
	assign sat_acc = lts_pkg::sat32(acc_q);
	assign wr_data = cmd.wr_from_div ? div_quo : sat_acc;

	always_ff @(posedge clk) begin
		if (cmd.load_wr) begin
			coef_mem[cmd.load_addr[AW-1:0]] <= item.column_entry;
			rhs_mem[cmd.load_addr[AW-1:0]]  <= item.rhs_entry;
		end
		if (cmd.b_wr)
			b_mem[bw_a] <= wr_data;
		if (cmd.x_wr)
			x_mem[cmd.x_wr_addr[AW-1:0]] <= wr_data;
		if (cmd.rd_en) begin
			coef_rd_q <= coef_mem[cmd.coef_addr[AW-1:0]];
			rhs_rd_q  <= rhs_mem[cmd.rhs_addr[AW-1:0]];
			x_rd_q    <= x_mem[cmd.x_addr[AW-1:0]];
			b0_rd_q   <= b_mem[b0_a];
			b1_rd_q   <= b_mem[b1_a];
		end
		if (cmd.mul_en)
			p_s1 <= prod;
		case (cmd.acc_op)
			lts_pkg::ACC_CLR: acc_q <= '0;
			lts_pkg::ACC_SET: acc_q <= rnd;
			lts_pkg::ACC_ADD: acc_q <= acc_q + rnd;
			lts_pkg::ACC_LDX: acc_q <= 64'(x_rd_q);
			default:          acc_q <= acc_q;
		endcase
		case (cmd.lat_op)
			lts_pkg::LAT_E:   e_q   <= sat_acc;
			lts_pkg::LAT_DEN: den_q <= lts_pkg::sat32(ONE - 64'(sat_acc));
			lts_pkg::LAT_D:   d_q   <= div_quo;
			lts_pkg::LAT_NED: ned_q <= lts_pkg::sat32(64'sd0 - 64'(sat_acc));
			lts_pkg::LAT_Z:   z_q   <= lts_pkg::sat32(64'(rhs_rd_q) - 64'(sat_acc));
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sing_q <= 1'b0;
		else if (cmd.sing_clr)
			sing_q <= 1'b0;
		else if (div_done && div_zero)
			sing_q <= 1'b1;
	end

	assign status.div_done = div_done;
	assign x_value         = x_rd_q;
	assign singular        = sing_q;

endmodule

FILE: hw/rtl/lts_ctrl.sv
module lts_ctrl #(
	parameter int MAX_ORDER = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                is_last,
	input  lts_pkg::dp_status_t status,
	output logic                busy,
	output lts_pkg::ctrl_cmd_t  cmd
);

	localparam int CW = $clog2(MAX_ORDER + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ORDER);

	typedef enum logic [5:0] {
		S_LOAD, S_INIT_RD, S_B0_DIV, S_B0_WAIT, S_X0_DIV, S_X0_WAIT,
		S_E_RD, S_E_MUL, S_E_ACC, S_E_LAT, S_EE_MUL, S_EE_ACC, S_DEN,
		S_D_DIV, S_D_WAIT, S_ED_MUL, S_ED_ACC, S_NED,
		S_B_RD, S_B_MUL1, S_B_ACC1, S_B_MUL2, S_B_ACC2, S_B_WR,
		S_Z_RD, S_Z_MUL, S_Z_ACC, S_Z_RHS, S_Z_LAT,
		S_X_RD, S_X_MUL, S_X_ACC, S_X_WR, S_OUT_RD, S_OUT
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q, nord_q, n_q, i_q;
	logic          bank_q;
	logic [CW-1:0] cnt_inc;

	function automatic logic [lts_pkg::IDX_W-1:0] to_idx(input logic [CW-1:0] v);
		return lts_pkg::IDX_W'(v);
	endfunction

	assign cnt_inc = (cnt_q < MAX_CNT) ? cnt_q + CW'(1) : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= '0;
			nord_q  <= '0;
			n_q     <= '0;
			i_q     <= '0;
			bank_q  <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: if (start) begin
					cnt_q <= cnt_inc;
					if (is_last) begin
						nord_q  <= cnt_inc;
						bank_q  <= 1'b0;
						state_q <= S_INIT_RD;
					end
				end
				S_INIT_RD: state_q <= S_B0_DIV;
				S_B0_DIV:  state_q <= S_B0_WAIT;
				S_B0_WAIT: if (status.div_done) state_q <= S_X0_DIV;
				S_X0_DIV:  state_q <= S_X0_WAIT;
				S_X0_WAIT: if (status.div_done) begin
					n_q     <= CW'(1);
					i_q     <= '0;
					state_q <= (nord_q == CW'(1)) ? S_OUT_RD : S_E_RD;
				end
				S_E_RD:  state_q <= S_E_MUL;
				S_E_MUL: state_q <= S_E_ACC;
				S_E_ACC: begin
					if (i_q + CW'(1) == n_q) begin
						i_q     <= '0;
						state_q <= S_E_LAT;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_E_RD;
					end
				end
				S_E_LAT:  state_q <= S_EE_MUL;
				S_EE_MUL: state_q <= S_EE_ACC;
				S_EE_ACC: state_q <= S_DEN;
				S_DEN:    state_q <= S_D_DIV;
				S_D_DIV:  state_q <= S_D_WAIT;
				S_D_WAIT: if (status.div_done) state_q <= S_ED_MUL;
				S_ED_MUL: state_q <= S_ED_ACC;
				S_ED_ACC: state_q <= S_NED;
				S_NED: begin
					i_q     <= '0;
					state_q <= S_B_RD;
				end
				S_B_RD:   state_q <= S_B_MUL1;
				S_B_MUL1: state_q <= S_B_ACC1;
				S_B_ACC1: state_q <= S_B_MUL2;
				S_B_MUL2: state_q <= S_B_ACC2;
				S_B_ACC2: state_q <= S_B_WR;
				S_B_WR: begin
					if (i_q == n_q) begin
						i_q     <= '0;
						bank_q  <= ~bank_q;
						state_q <= S_Z_RD;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_B_RD;
					end
				end
				S_Z_RD:  state_q <= S_Z_MUL;
				S_Z_MUL: state_q <= S_Z_ACC;
				S_Z_ACC: begin
					if (i_q + CW'(1) == n_q) begin
						i_q     <= '0;
						state_q <= S_Z_RHS;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_Z_RD;
					end
				end
				S_Z_RHS: state_q <= S_Z_LAT;
				S_Z_LAT: state_q <= S_X_RD;
				S_X_RD:  state_q <= S_X_MUL;
				S_X_MUL: state_q <= S_X_ACC;
				S_X_ACC: state_q <= S_X_WR;
				S_X_WR: begin
					if (i_q == n_q) begin
						i_q <= '0;
						if (n_q + CW'(1) == nord_q) begin
							state_q <= S_OUT_RD;
						end else begin
							n_q     <= n_q + CW'(1);
							state_q <= S_E_RD;
						end
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_X_RD;
					end
				end
				S_OUT_RD: state_q <= S_OUT;
				S_OUT: begin
					if (i_q + CW'(1) == nord_q) begin
						i_q     <= '0;
						cnt_q   <= '0;
						state_q <= S_LOAD;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_OUT_RD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.mul_sel  = lts_pkg::MUL_TB;
		cmd.acc_op   = lts_pkg::ACC_HOLD;
		cmd.lat_op   = lts_pkg::LAT_NONE;
		case (state_q)
			S_LOAD: begin
				cmd.load_wr   = start && (cnt_q < MAX_CNT);
				cmd.load_addr = to_idx(cnt_q);
				cmd.sing_clr  = start;
			end
			S_INIT_RD: cmd.rd_en = 1'b1;
			S_B0_DIV: begin
				cmd.div_start    = 1'b1;
				cmd.div_den_coef = 1'b1;
			end
			S_B0_WAIT: begin
				cmd.b_wr        = status.div_done;
				cmd.wr_from_div = 1'b1;
			end
			S_X0_DIV: begin
				cmd.div_start    = 1'b1;
				cmd.div_num_rhs  = 1'b1;
				cmd.div_den_coef = 1'b1;
			end
			S_X0_WAIT: begin
				cmd.x_wr        = status.div_done;
				cmd.wr_from_div = 1'b1;
			end
			S_E_RD: begin
				cmd.rd_en     = 1'b1;
				cmd.coef_addr = to_idx(i_q + CW'(1));
				cmd.b0_addr   = {bank_q, to_idx(i_q)};
				if (i_q == '0)
					cmd.acc_op = lts_pkg::ACC_CLR;
			end
			S_E_MUL: begin
				cmd.mul_sel = lts_pkg::MUL_TB;
				cmd.mul_en  = 1'b1;
			end
			S_E_ACC:  cmd.acc_op = lts_pkg::ACC_ADD;
			S_E_LAT:  cmd.lat_op = lts_pkg::LAT_E;
			S_EE_MUL: begin
				cmd.mul_sel = lts_pkg::MUL_EE;
				cmd.mul_en  = 1'b1;
			end
			S_EE_ACC: cmd.acc_op    = lts_pkg::ACC_SET;
			S_DEN:    cmd.lat_op    = lts_pkg::LAT_DEN;
			S_D_DIV:  cmd.div_start = 1'b1;
			S_D_WAIT: if (status.div_done) cmd.lat_op = lts_pkg::LAT_D;
			S_ED_MUL: begin
				cmd.mul_sel = lts_pkg::MUL_ED;
				cmd.mul_en  = 1'b1;
			end
			S_ED_ACC: cmd.acc_op = lts_pkg::ACC_SET;
			S_NED:    cmd.lat_op = lts_pkg::LAT_NED;
			S_B_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.b0_addr = {bank_q, to_idx(i_q - CW'(1))};
				cmd.b1_addr = {bank_q, to_idx(n_q - CW'(1) - i_q)};
			end
			S_B_MUL1: begin
				cmd.mul_sel = lts_pkg::MUL_BD;
				cmd.mul_en  = 1'b1;
			end
			S_B_ACC1: cmd.acc_op = (i_q != '0) ? lts_pkg::ACC_SET : lts_pkg::ACC_CLR;
			S_B_MUL2: begin
				cmd.mul_sel = lts_pkg::MUL_FN;
				cmd.mul_en  = 1'b1;
			end
			S_B_ACC2: cmd.acc_op = (i_q != n_q) ? lts_pkg::ACC_ADD : lts_pkg::ACC_HOLD;
			S_B_WR: begin
				cmd.b_wr      = 1'b1;
				cmd.b_wr_addr = {~bank_q, to_idx(i_q)};
			end
			S_Z_RD: begin
				cmd.rd_en     = 1'b1;
				cmd.coef_addr = to_idx(n_q - i_q);
				cmd.x_addr    = to_idx(i_q);
				if (i_q == '0)
					cmd.acc_op = lts_pkg::ACC_CLR;
			end
			S_Z_MUL: begin
				cmd.mul_sel = lts_pkg::MUL_TX;
				cmd.mul_en  = 1'b1;
			end
			S_Z_ACC: cmd.acc_op = lts_pkg::ACC_ADD;
			S_Z_RHS: begin
				cmd.rd_en    = 1'b1;
				cmd.rhs_addr = to_idx(n_q);
			end
			S_Z_LAT: cmd.lat_op = lts_pkg::LAT_Z;
			S_X_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.b0_addr = {bank_q, to_idx(i_q)};
				cmd.x_addr  = to_idx(i_q);
			end
			S_X_MUL: begin
				cmd.mul_sel = lts_pkg::MUL_BZ;
				cmd.mul_en  = 1'b1;
				cmd.acc_op  = (i_q == n_q) ? lts_pkg::ACC_CLR : lts_pkg::ACC_LDX;
			end
			S_X_ACC: cmd.acc_op = lts_pkg::ACC_ADD;
			S_X_WR: begin
				cmd.x_wr      = 1'b1;
				cmd.x_wr_addr = to_idx(i_q);
			end
			S_OUT_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.x_addr = to_idx(i_q);
			end
			S_OUT: begin
				cmd.out_valid = 1'b1;
				cmd.out_last  = (i_q + CW'(1) == nord_q);
				cmd.out_index = 6'(i_q);
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_LOAD);

endmodule

FILE: hw/rtl/levinson_toeplitz_solver_unit.sv
// Symmetric Toeplitz solver, Levinson recursion, signed fixed point.
// Input channel: drive item and raise start; a transfer happens at each
// rising edge with start high and busy low. Each transfer loads one
// first-column coefficient and one right-hand-side entry; one with
// item.is_last set ends the load and starts the solve (order N = entries
// loaded, capped at MAX_ORDER; extra entries are dropped).
// Result channel: result_strobe is high for exactly one cycle per solution
// element, x[0] first; result.last_element marks x[N-1] and result.singular
// flags a zero divisor. The receiver cannot stall; each result is a
// transfer in the cycle it is shown.
// The solve runs on one shared multiplier and one radix-2 divider; busy
// stays high from the last transfer to the final result.
// Reset (arst_n low) returns to the load state with an empty load; stored
// coefficients are not cleared and are not read before rewritten.
module levinson_toeplitz_solver_unit #(
	parameter int MAX_ORDER = 32,
	parameter int FRAC_BITS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  lts_pkg::in_item_t  item,
	output logic               result_strobe,
	output lts_pkg::out_item_t result
);

	lts_pkg::ctrl_cmd_t  cmd;
	lts_pkg::dp_status_t status;
	logic signed [31:0]  x_value;
	logic                singular;

	// sequencer: load count, order and element counters, bank select
	lts_ctrl #(
		.MAX_ORDER (MAX_ORDER)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.is_last (item.is_last),
		.status  (status),
		.busy    (busy),
		.cmd     (cmd)
	);

	// stores, multiply-accumulate, scalar registers and divider
	lts_dpath #(
		.MAX_ORDER (MAX_ORDER),
		.FRAC_BITS (FRAC_BITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cmd      (cmd),
		.status   (status),
		.x_value  (x_value),
		.singular (singular)
	);

	// present one solution element per strobe
	assign result_strobe         = cmd.out_valid;
	assign result.solution_value = x_value;
	assign result.solution_index = cmd.out_index;
	assign result.last_element   = cmd.out_last;
	assign result.singular       = singular;

endmodule
